[rtl/core/cusf_pkg.sv]
// ----------------------------------------------------------------------------
// cusf_pkg
// Shared types, codes and byte-shaping helpers for the camera UART framer.
// ----------------------------------------------------------------------------
package cusf_pkg;

  // Input actions
  localparam logic [1:0] ACT_FRAME     = 2'd0;
  localparam logic [1:0] ACT_PIXEL     = 2'd1;
  localparam logic [1:0] ACT_DBG_BEGIN = 2'd2;
  localparam logic [1:0] ACT_DBG_CHAR  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_LINE_LENGTH  = 2'd0;
  localparam logic [1:0] REG_LINE_COUNT   = 2'd1;
  localparam logic [1:0] REG_PIXEL_FORMAT = 2'd2;

  // Queue commands passed from front to back
  localparam int unsigned CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_FRAME    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PIXEL    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DBG_HDR  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CHAR     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CHAR_SUM = 3'd4;

  // Framing constants
  localparam logic [7:0] MARKER_BYTE  = 8'h00;
  localparam logic [7:0] FRAME_LEN    = 8'h04;
  localparam logic [7:0] FRAME_CODE   = 8'h11;
  localparam logic [7:0] DEBUG_CODE   = 8'h13;
  localparam logic [7:0] MAX_TEXT     = 8'd254;
  localparam logic [7:0] HI_TEST_BIT  = 8'b0010_0000;
  localparam logic [7:0] HI_FORCE_BIT = 8'b0000_1000;
  localparam logic [7:0] LO_TEST_BIT  = 8'b0000_1000;
  localparam logic [7:0] LO_FORCE_BIT = 8'b0010_0000;
  localparam logic [7:0] LO_NZ_BIT    = 8'b0000_0001;

  // Command queue depth
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Reset values of the configuration registers
  localparam logic [9:0] LINE_LENGTH_RST  = 10'd320;
  localparam logic [9:0] LINE_COUNT_RST   = 10'd240;
  localparam logic [3:0] PIXEL_FORMAT_RST = 4'd1;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic [7:0] text_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [9:0] line_length;
    logic [9:0] line_count;
    logic [3:0] pixel_format;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic [7:0]       b0;
    logic [7:0]       b1;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // High pixel byte: bit 5 set clears bit 3, else bit 3 is set
  function automatic logic [7:0] shape_high(input logic [7:0] b);
    shape_high = ((b & HI_TEST_BIT) != 8'h00) ? (b & ~HI_FORCE_BIT) : (b | HI_FORCE_BIT);
  endfunction

  // Low pixel byte: bit 3 copies into bit 5, bit 0 always set
  function automatic logic [7:0] shape_low(input logic [7:0] b);
    shape_low = ((b & LO_TEST_BIT) != 8'h00) ? (b | LO_FORCE_BIT | LO_NZ_BIT)
                                             : ((b & ~LO_FORCE_BIT) | LO_NZ_BIT);
  endfunction

  // Number of output bytes a command expands to
  function automatic logic [2:0] cmd_len(input logic [CMD_W-1:0] op);
    unique case (op)
      CMD_FRAME:    cmd_len = 3'd7;
      CMD_DBG_HDR:  cmd_len = 3'd3;
      CMD_CHAR_SUM: cmd_len = 3'd2;
      default:      cmd_len = 3'd1;
    endcase
  endfunction

endpackage

[rtl/core/cusf_front.sv]
// ----------------------------------------------------------------------------
// cusf_front
// Accepts input beats, tracks pixel phase and debug message state, and
// pushes one command per beat that produces output.
// ----------------------------------------------------------------------------
module cusf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cusf_pkg::in_item_t  in_item,
  input  cusf_pkg::q_stat_t   q_stat,
  output logic                push,
  output cusf_pkg::cmd_t      push_cmd
);
  import cusf_pkg::*;

  logic       hbn_r, hbn_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic       accept;
  logic [7:0] tlen;
  logic [7:0] char_sum;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign tlen     = (in_item.text_length > MAX_TEXT) ? MAX_TEXT : in_item.text_length;
  assign char_sum = sum_r ^ in_item.data_byte;

  // Classify the beat and build its command
  always_comb begin
    hbn_nxt  = hbn_r;
    sum_nxt  = sum_r;
    rem_nxt  = rem_r;
    push     = 1'b0;
    push_cmd = '{op: CMD_PIXEL, b0: in_item.data_byte, b1: 8'h00};
    if (accept) begin
      unique case (in_item.action)
        ACT_FRAME: begin
          push        = 1'b1;
          push_cmd.op = CMD_FRAME;
          hbn_nxt     = 1'b1;
          sum_nxt     = 8'h00;
          rem_nxt     = 8'h00;
        end
        ACT_PIXEL: begin
          push        = 1'b1;
          push_cmd.op = CMD_PIXEL;
          push_cmd.b0 = hbn_r ? shape_high(in_item.data_byte) : shape_low(in_item.data_byte);
          hbn_nxt     = ~hbn_r;
        end
        ACT_DBG_BEGIN: begin
          if (tlen == 8'h00) begin
            sum_nxt = 8'h00;
            rem_nxt = 8'h00;
          end else begin
            push        = 1'b1;
            push_cmd.op = CMD_DBG_HDR;
            push_cmd.b0 = tlen + 8'd1;
            sum_nxt     = DEBUG_CODE;
            rem_nxt     = tlen;
          end
        end
        default: begin
          // debug character; drop it when no message is open
          if (rem_r != 8'h00) begin
            push    = 1'b1;
            rem_nxt = rem_r - 8'd1;
            if (rem_r == 8'd1) begin
              push_cmd.op = CMD_CHAR_SUM;
              push_cmd.b1 = char_sum;
              sum_nxt     = 8'h00;
            end else begin
              push_cmd.op = CMD_CHAR;
              sum_nxt     = char_sum;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hbn_r <= 1'b1;
      sum_r <= 8'h00;
      rem_r <= 8'h00;
    end else begin
      hbn_r <= hbn_nxt;
      sum_r <= sum_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

[rtl/core/cusf_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// cusf_cmd_fifo
// Short command queue between front and back; head is shown directly.
// ----------------------------------------------------------------------------
module cusf_cmd_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cusf_pkg::cmd_t     push_cmd,
  input  logic               pop,
  output cusf_pkg::cmd_t     head_cmd,
  output cusf_pkg::q_stat_t  q_stat
);
  import cusf_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign q_stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_cmd     = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[rtl/core/cusf_back.sv]
// ----------------------------------------------------------------------------
// cusf_back
// Expands queued commands into UART bytes, one beat per cycle while a command
// is queued and out_stall is low, into an output register.
// ----------------------------------------------------------------------------
module cusf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  cusf_pkg::cfg_t      cfg,
  input  cusf_pkg::cmd_t      head_cmd,
  input  cusf_pkg::q_stat_t   q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output cusf_pkg::out_item_t out_item
);
  import cusf_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r;
  logic       advance;
  logic       at_end;
  logic [7:0] w_lo, h_lo, packed_b, frame_sum;
  logic [7:0] byte_sel;

  assign advance = !q_stat.empty && (!out_valid_r || !out_stall);
  assign at_end  = (idx_r == cmd_len(head_cmd.op) - 3'd1);
  assign pop     = advance && at_end;

  // Frame header fields
  assign w_lo      = cfg.line_length[7:0];
  assign h_lo      = cfg.line_count[7:0];
  assign packed_b  = {cfg.pixel_format, cfg.line_count[9:8], cfg.line_length[9:8]};
  assign frame_sum = FRAME_CODE ^ w_lo ^ h_lo ^ packed_b;

  // Select the byte for the current step
  always_comb begin
    byte_sel = head_cmd.b0;
    unique case (head_cmd.op)
      CMD_FRAME: begin
        case (idx_r)
          3'd0:    byte_sel = MARKER_BYTE;
          3'd1:    byte_sel = FRAME_LEN;
          3'd2:    byte_sel = FRAME_CODE;
          3'd3:    byte_sel = w_lo;
          3'd4:    byte_sel = h_lo;
          3'd5:    byte_sel = packed_b;
          default: byte_sel = frame_sum;
        endcase
      end
      CMD_DBG_HDR: begin
        case (idx_r)
          3'd0:    byte_sel = MARKER_BYTE;
          3'd1:    byte_sel = head_cmd.b0;
          default: byte_sel = DEBUG_CODE;
        endcase
      end
      CMD_CHAR_SUM: byte_sel = (idx_r == 3'd0) ? head_cmd.b0 : head_cmd.b1;
      default:      byte_sel = head_cmd.b0;
    endcase
  end

  // Step through the command, load or drain the output register
  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (advance) begin
      idx_nxt       = at_end ? 3'd0 : idx_r + 3'd1;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= '{tx_byte: byte_sel, last: at_end};
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Step counter rests at zero while no command is queued
  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> idx_r == 3'd0)
    else $error("step counter not at zero with empty queue");

  // Step counter never runs past the command length
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    !q_stat.empty |-> idx_r < cmd_len(head_cmd.op))
    else $error("step counter beyond command length");

  // Final step of a frame raises last on the next output beat
  a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && head_cmd.op == CMD_FRAME && idx_r == 3'd6) |=> out_valid_r && out_item_r.last)
    else $error("frame checksum beat without last");

  // Popping a command only happens at its final step
  a_pop_end: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> at_end && !q_stat.empty)
    else $error("command popped before its last byte");

endmodule

[rtl/core/camera_uart_stream_framer_top.sv]
// ----------------------------------------------------------------------------
// camera_uart_stream_framer_top
// Frames a camera RGB565 byte stream and debug text into UART command bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_item) carries one action per beat:
//   start frame, pixel byte, debug begin or debug character. Output channel
//   (out_valid / out_stall / out_item) carries one UART byte per beat, with
//   last set on the final byte produced by an input beat.
//   Configuration (cfg_we / cfg_index / cfg_wdata) sets width, height and
//   pixel format; write it only while the block is idle.
// Path: an accepted beat's command is written into the command queue; the
//   back end loads the output register from the queue head to offer a byte.
// Throughput: one input beat per cycle while the command queue is not full; a
//   start frame expands to seven output bytes, a debug begin to three, a
//   closing character to two. The back end emits one byte per cycle when not
//   stalled; a four-entry command queue lets the front end take beats meanwhile.
// Reset: rst_n clears the queue, output register, pixel phase (high byte
//   next) and any open debug message; configuration returns to 320x240, RGB565.
// Stall: out_stall holds the output beat; the queue fills and then in_stall
//   rises until the back end drains a command.
// ----------------------------------------------------------------------------
module camera_uart_stream_framer_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cusf_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output cusf_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [9:0]          cfg_wdata
);
  import cusf_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  cmd_t    push_cmd, head_cmd;
  q_stat_t q_stat;
  logic    push, pop;

  // Decode configuration writes; unknown indexes are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_LENGTH:  cfg_nxt.line_length  = cfg_wdata;
        REG_LINE_COUNT:   cfg_nxt.line_count   = cfg_wdata;
        REG_PIXEL_FORMAT: cfg_nxt.pixel_format = cfg_wdata[3:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{line_length: LINE_LENGTH_RST, line_count: LINE_COUNT_RST,
                 pixel_format: PIXEL_FORMAT_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cusf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  cusf_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  cusf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head_cmd  (head_cmd),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

[tb/sv/camera_uart_stream_framer_top_tb.sv]
// ----------------------------------------------------------------------------
// camera_uart_stream_framer_top_tb
// Self-checking bench for the camera UART framer. A queue of pending input
// beats feeds a clocked driver. A clocked monitor compares every output byte
// with the bytes predicted at input acceptance. Both sides idle at random,
// and one long receiver hold-off backs the block up into input stall.
// Configuration changes only between phases, once the block has drained.
// ----------------------------------------------------------------------------
module camera_uart_stream_framer_top_tb;
  import cusf_pkg::*;

  localparam int unsigned RUN_LIMIT = 500000;
  localparam int unsigned LONG_HOLD = 150;
  localparam int unsigned DRAIN_WAIT = 8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_LINE_LENGTH;
  logic [9:0] cfg_wdata = '0;

  camera_uart_stream_framer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Beats waiting to be offered and bytes the block still owes
  in_item_t  pending[$];
  out_item_t tx_due[$];

  // Shadow of the framer: configuration and stream state
  logic [9:0] cur_len = LINE_LENGTH_RST;
  logic [9:0] cur_cnt = LINE_COUNT_RST;
  logic [3:0] cur_fmt = PIXEL_FORMAT_RST;
  logic       hi_next = 1'b1;
  logic [7:0] msg_sum = 8'h00;
  logic [7:0] chars_left = 8'h00;

  int          err_count = 0;
  int unsigned cycles = 0;
  int          gap_left = 0;
  int          hold_left = 0;
  int          run_left = 0;
  bit          no_gaps = 1'b0;
  bit          press_req = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (err_count < 50)
      $display("mismatch %s: got %02h want %02h at cycle %0d", what, got, want, cycles);
    err_count++;
  endtask

  task automatic owe_tx(input logic [7:0] b, input logic fin);
    out_item_t o;
    o.tx_byte = b;
    o.last = fin;
    tx_due.push_back(o);
  endtask

  // Predict the UART bytes that one accepted input beat produces
  task automatic frame_item(input in_item_t it);
    logic [7:0] w_lo, h_lo, pk, sum, n, px;
    case (it.action)
      ACT_FRAME: begin
        w_lo = cur_len[7:0];
        h_lo = cur_cnt[7:0];
        pk = {cur_fmt, cur_cnt[9:8], cur_len[9:8]};
        sum = FRAME_CODE ^ w_lo ^ h_lo ^ pk;
        owe_tx(MARKER_BYTE, 1'b0);
        owe_tx(FRAME_LEN, 1'b0);
        owe_tx(FRAME_CODE, 1'b0);
        owe_tx(w_lo, 1'b0);
        owe_tx(h_lo, 1'b0);
        owe_tx(pk, 1'b0);
        owe_tx(sum, 1'b1);
        // a new frame drops any open message
        hi_next = 1'b1;
        chars_left = 8'h00;
        msg_sum = 8'h00;
      end
      ACT_PIXEL: begin
        px = it.data_byte;
        if (hi_next) begin
          px[3] = ~it.data_byte[5];
        end else begin
          px[5] = it.data_byte[3];
          px[0] = 1'b1;
        end
        hi_next = ~hi_next;
        owe_tx(px, 1'b1);
      end
      ACT_DBG_BEGIN: begin
        n = (it.text_length > MAX_TEXT) ? MAX_TEXT : it.text_length;
        if (n == 8'h00) begin
          chars_left = 8'h00;
          msg_sum = 8'h00;
        end else begin
          owe_tx(MARKER_BYTE, 1'b0);
          owe_tx(n + 8'd1, 1'b0);
          owe_tx(DEBUG_CODE, 1'b1);
          msg_sum = DEBUG_CODE;
          chars_left = n;
        end
      end
      default: begin
        // characters outside a message vanish
        if (chars_left != 8'h00) begin
          msg_sum = msg_sum ^ it.data_byte;
          chars_left = chars_left - 8'd1;
          if (chars_left == 8'h00) begin
            owe_tx(it.data_byte, 1'b0);
            owe_tx(msg_sum, 1'b1);
            msg_sum = 8'h00;
          end else begin
            owe_tx(it.data_byte, 1'b1);
          end
        end
      end
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  // Driver: hold a stalled beat, else take the next pending one after its gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
      // hold the beat unchanged
    end else begin
      if (in_valid) frame_item(in_item);
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending.size() != 0) begin
        in_item <= pending.pop_front();
        in_valid <= 1'b1;
        gap_left = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: runs of free cycles, short and long stalls, one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (press_req) begin
      press_req = 1'b0;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (run_left > 0) begin
      run_left--;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 1) == 0) begin
      run_left = $urandom_range(0, 30);
      out_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0:       hold_left = $urandom_range(15, 30);
        1, 2, 3: hold_left = $urandom_range(4, 8);
        default: hold_left = $urandom_range(0, 2);
      endcase
      out_stall <= 1'b1;
    end
  end

  // Monitor: check each output beat against the oldest owed byte
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (tx_due.size() == 0) begin
        report_mismatch("unexpected byte", out_item.tx_byte, 8'h00);
      end else begin
        want = tx_due.pop_front();
        if (out_item.tx_byte !== want.tx_byte)
          report_mismatch("tx_byte", out_item.tx_byte, want.tx_byte);
        if (out_item.last !== want.last)
          report_mismatch("last", {7'd0, out_item.last}, {7'd0, want.last});
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic queue_beat(input logic [1:0] act, input logic [7:0] d, input logic [7:0] n);
    in_item_t it;
    it.action = act;
    it.data_byte = d;
    it.text_length = n;
    pending.push_back(it);
  endtask

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  // Random traffic: pixel runs, whole messages, broken messages, frames, noise
  task automatic add_traffic(input int n);
    int made, pick, len, k, cap;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        len = $urandom_range(1, 12);
        repeat (len) queue_beat(ACT_PIXEL, rnd8(), rnd8());
        made += len;
      end else if (pick < 65) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        queue_beat(ACT_DBG_BEGIN, rnd8(), 8'(len));
        made++;
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 5) == 0) begin
            queue_beat(ACT_PIXEL, rnd8(), rnd8());
            made++;
          end
          queue_beat(ACT_DBG_CHAR, rnd8(), rnd8());
          made++;
        end
      end else if (pick < 75) begin
        // cut a message short with a frame or an empty begin
        len = $urandom_range(0, 255);
        queue_beat(ACT_DBG_BEGIN, rnd8(), 8'(len));
        made++;
        cap = (len > 7) ? 6 : len - 1;
        k = (cap > 0) ? $urandom_range(0, cap) : 0;
        repeat (k) queue_beat(ACT_DBG_CHAR, rnd8(), rnd8());
        made += k;
        if ($urandom_range(0, 1) == 0) begin
          queue_beat(ACT_FRAME, rnd8(), rnd8());
        end else begin
          queue_beat(ACT_DBG_BEGIN, rnd8(), 8'h00);
        end
        made++;
      end else if (pick < 85) begin
        queue_beat(ACT_FRAME, rnd8(), rnd8());
        made++;
      end else if (pick < 93) begin
        queue_beat(ACT_DBG_CHAR, rnd8(), rnd8());
        made++;
      end else begin
        queue_beat(ACT_DBG_BEGIN, rnd8(), 8'h00);
        made++;
      end
    end
  endtask

  // Wait for every beat to be taken and every owed byte to arrive
  task automatic settle();
    while (pending.size() != 0 || in_valid || tx_due.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LINE_LENGTH:  cur_len = val;
      REG_LINE_COUNT:   cur_cnt = val;
      REG_PIXEL_FORMAT: cur_fmt = val[3:0];
      default: ;
    endcase
  endtask

  task automatic write_setup(input logic [9:0] len, input logic [9:0] cnt,
                             input logic [9:0] fmt);
    write_reg(REG_LINE_LENGTH, len);
    write_reg(REG_LINE_COUNT, cnt);
    write_reg(REG_PIXEL_FORMAT, fmt);
    @(negedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset header, both pixel rules, message corner cases
    queue_beat(ACT_FRAME, 8'h00, 8'h00);
    queue_beat(ACT_PIXEL, 8'h00, 8'h00);
    queue_beat(ACT_PIXEL, 8'hFF, 8'hFF);
    queue_beat(ACT_PIXEL, 8'hFF, 8'h00);
    queue_beat(ACT_PIXEL, 8'h00, 8'hFF);
    queue_beat(ACT_PIXEL, 8'h20, 8'h00);
    queue_beat(ACT_PIXEL, 8'hD7, 8'h00);
    queue_beat(ACT_DBG_CHAR, 8'h41, 8'h05);
    queue_beat(ACT_DBG_BEGIN, 8'h00, 8'h00);
    queue_beat(ACT_DBG_BEGIN, 8'hFF, 8'd3);
    queue_beat(ACT_PIXEL, 8'h5A, 8'h00);
    queue_beat(ACT_DBG_CHAR, 8'h61, 8'h00);
    queue_beat(ACT_DBG_CHAR, 8'h62, 8'h00);
    queue_beat(ACT_DBG_CHAR, 8'h63, 8'h00);
    queue_beat(ACT_DBG_BEGIN, 8'h00, 8'hFF);
    queue_beat(ACT_DBG_CHAR, 8'h00, 8'h00);
    queue_beat(ACT_DBG_CHAR, 8'hFF, 8'h00);
    queue_beat(ACT_DBG_BEGIN, 8'h00, 8'd1);
    queue_beat(ACT_DBG_CHAR, 8'hFF, 8'hFF);
    queue_beat(ACT_DBG_BEGIN, 8'h00, 8'd2);
    queue_beat(ACT_DBG_CHAR, 8'h7E, 8'h00);
    queue_beat(ACT_FRAME, 8'hFF, 8'hFF);
    queue_beat(ACT_DBG_CHAR, 8'h33, 8'h00);
    settle();

    // Largest sizes and format
    write_setup(10'd1023, 10'd1023, 10'd15);
    queue_beat(ACT_FRAME, rnd8(), rnd8());
    add_traffic(60);
    settle();

    // Smallest sizes, format zero
    write_setup(10'd1, 10'd1, 10'd0);
    queue_beat(ACT_FRAME, rnd8(), rnd8());
    add_traffic(60);
    settle();

    // Back-pressure: receiver holds off while the sender streams without gaps
    write_setup(10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)),
                10'($urandom_range(0, 1023)));
    no_gaps = 1'b1;
    press_req = 1'b1;
    queue_beat(ACT_FRAME, rnd8(), rnd8());
    repeat (30) queue_beat(ACT_PIXEL, rnd8(), rnd8());
    queue_beat(ACT_DBG_BEGIN, rnd8(), 8'd4);
    repeat (4) queue_beat(ACT_DBG_CHAR, rnd8(), rnd8());
    queue_beat(ACT_FRAME, rnd8(), rnd8());
    while (pending.size() != 0) @(negedge clk);
    no_gaps = 1'b0;
    add_traffic(50);
    settle();

    // Two more random settings
    repeat (2) begin
      write_setup(10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)),
                  10'($urandom_range(0, 15)));
      queue_beat(ACT_FRAME, rnd8(), rnd8());
      add_traffic(60);
      settle();
    end

    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
